// ===== hw/rtl/eaf_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// eaf_pkg: shared definitions for the encoder angle filter
// Field widths, conversion constants, reciprocal multipliers for the
// constant divisions, register indexes and the structs between modules.
// ---------------------------------------------------------------------------
package eaf_pkg;

   // Block configuration.
   localparam int AVG_LEN        = 40;
   localparam int COUNTS_DIVISOR = 360;

   // Conversion constants.
   localparam int          FULL_TURN   = 36000;
   localparam logic [31:0] LIN_BASE    = 32'h0337_2CF4;
   localparam int          LIN_SCALE   = 100;
   localparam int          LIN_DIVISOR = 2564;

   // Field widths.
   localparam int WORD_W      = 16;
   localparam int TURN_W      = 16;
   localparam int SINGLE_W    = 17;
   localparam int POS_W       = 32;
   localparam int ANGLE_W     = 32;
   localparam int THR_W       = 16;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 32;

   // Every raw angle lies within +/-837552 centidegrees.
   localparam int RAW_W = 21;

   // Calculation pipeline depth.
   localparam int CALC_STAGES = 5;

   // Reciprocals for exact truncating division of a POS_W-bit magnitude:
   // floor(x / d) = (x * ceil(2^(N+L) / d)) >> (N+L), with L = clog2(d).
   localparam int MAGIC_W = POS_W + 1;
   localparam int PROD_W  = POS_W + MAGIC_W;

   localparam int DIV_SH = POS_W + $clog2(COUNTS_DIVISOR);
   localparam logic [MAGIC_W-1:0] DIV_MAGIC = MAGIC_W'(
      ((64'd1 << DIV_SH) + 64'(COUNTS_DIVISOR - 1)) / 64'(COUNTS_DIVISOR));

   localparam int LIN_SH = POS_W + $clog2(LIN_DIVISOR);
   localparam logic [MAGIC_W-1:0] LIN_MAGIC = MAGIC_W'(
      ((64'd1 << LIN_SH) + 64'(LIN_DIVISOR - 1)) / 64'(LIN_DIVISOR));

   localparam int MOD_SH = POS_W + $clog2(FULL_TURN);
   localparam logic [MAGIC_W-1:0] MOD_MAGIC = MAGIC_W'(
      ((64'd1 << MOD_SH) + 64'(FULL_TURN - 1)) / 64'(FULL_TURN));

   // Quotient and remainder widths of the shared and modulo dividers.
   localparam int QDIV_W  = POS_W - $clog2(COUNTS_DIVISOR);
   localparam int QLIN_W  = POS_W - $clog2(LIN_DIVISOR);
   localparam int Q_W     = (QDIV_W > QLIN_W) ? QDIV_W : QLIN_W;
   localparam int MOD_Q_W = POS_W - $clog2(FULL_TURN);
   localparam int REM_W   = $clog2(FULL_TURN);

   // Moving-average window sum and its mean.
   localparam int SUM_W        = RAW_W + $clog2(AVG_LEN);
   localparam int MEAN_N       = SUM_W - 1;
   localparam int MEAN_MAGIC_W = MEAN_N + 1;
   localparam int MEAN_PROD_W  = MEAN_N + MEAN_MAGIC_W;
   localparam int MEAN_SH      = MEAN_N + $clog2(AVG_LEN);
   localparam logic [MEAN_MAGIC_W-1:0] MEAN_MAGIC = MEAN_MAGIC_W'(
      ((64'd1 << MEAN_SH) + 64'(AVG_LEN - 1)) / 64'(AVG_LEN));
   localparam int CNT_W = $clog2(AVG_LEN + 1);

   // Board modes.
   localparam logic BOARD_MODE_DIVIDED = 1'b0;
   localparam logic BOARD_MODE_LINEAR  = 1'b1;

   localparam logic [THR_W-1:0] THRESHOLD_RESET = 16'd4000;

   // Register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ANGLE_OFFSET     = 8'd0,
      CSR_BOARD_MODE       = 8'd1,
      CSR_REJECT_THRESHOLD = 8'd2
   } csr_index_type;

   // Configuration seen by the datapath.
   typedef struct packed {
      logic signed [POS_W-1:0] offset;
      logic                    mode;
      logic [THR_W-1:0]        threshold;
   } cfg_type;

   // Raw angle item between the calculation pipeline and the filter.
   typedef struct packed {
      logic signed [RAW_W-1:0] angle;
      logic [TURN_W-1:0]       turn_count;
      logic [SINGLE_W-1:0]     single_turn;
   } raw_item_type;

endpackage : eaf_pkg
`default_nettype wire

// ===== hw/rtl/eaf_angle_calc.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// eaf_angle_calc: raw angle pipeline
// Unpacks the encoder words and converts the position into a raw
// centidegree angle in five stages, with flow control per stage.
// ---------------------------------------------------------------------------
module eaf_angle_calc (
   input  logic                         clock,
   input  logic                         reset,
   input  eaf_pkg::cfg_type             cfg,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [eaf_pkg::WORD_W-1:0]   word_first,
   input  logic [eaf_pkg::WORD_W-1:0]   word_second,
   input  logic [eaf_pkg::WORD_W-1:0]   word_third,
   output logic                         out_valid,
   input  logic                         out_ready,
   output eaf_pkg::raw_item_type        out_item
);
   import eaf_pkg::*;

   typedef struct packed {
      logic [TURN_W-1:0]   turns;
      logic [SINGLE_W-1:0] single;
      logic                mode;
      logic                neg;
      logic [POS_W-1:0]    mag;
   } st1_type;

   typedef struct packed {
      logic [TURN_W-1:0]   turns;
      logic [SINGLE_W-1:0] single;
      logic                mode;
      logic                neg;
      logic [Q_W-1:0]      quo;
   } st2_type;

   typedef struct packed {
      logic [TURN_W-1:0]       turns;
      logic [SINGLE_W-1:0]     single;
      logic                    mode;
      logic signed [RAW_W-1:0] lin_raw;
      logic                    neg;
      logic [POS_W-1:0]        mag;
   } st3_type;

   typedef struct packed {
      logic [TURN_W-1:0]       turns;
      logic [SINGLE_W-1:0]     single;
      logic                    mode;
      logic signed [RAW_W-1:0] lin_raw;
      logic                    neg;
      logic [POS_W-1:0]        mag;
      logic [MOD_Q_W-1:0]      quo;
   } st4_type;

   logic [CALC_STAGES-1:0] valid_ff;
   logic [CALC_STAGES-1:0] valid_in;
   logic [CALC_STAGES-1:0] stage_ready;

   st1_type      st1_ff, st1_in;
   st2_type      st2_ff, st2_in;
   st3_type      st3_ff, st3_in;
   st4_type      st4_ff, st4_in;
   raw_item_type st5_ff, st5_in;

   logic [POS_W-1:0]   pos_u;
   logic [POS_W-1:0]   lin_t;
   logic [MAGIC_W-1:0] div_magic;
   logic [PROD_W-1:0]  div_prod;
   logic [POS_W-1:0]   quo_s;
   logic [POS_W-1:0]   mod_t;
   logic [PROD_W-1:0]  mod_prod;
   logic [REM_W-1:0]   rem;
   logic signed [RAW_W-1:0] mod_raw;

   // A stage takes a new transfer when it is empty or its contents move on.
   always_comb begin
      stage_ready[CALC_STAGES-1] = !valid_ff[CALC_STAGES-1] || out_ready;
      for (int k = CALC_STAGES - 2; k >= 0; k--) begin
         stage_ready[k] = !valid_ff[k] || stage_ready[k+1];
      end
      valid_in[0] = in_valid;
      for (int k = 1; k < CALC_STAGES; k++) begin
         valid_in[k] = valid_ff[k-1];
      end
   end

   assign in_ready  = stage_ready[0];
   assign out_valid = valid_ff[CALC_STAGES-1];
   assign out_item  = st5_ff;

   // Stage 1: unpack the words and form the magnitude to divide.
   always_comb begin
      st1_in.turns  = {word_first[6:0], word_second[15:7]};
      st1_in.single = {word_second[6:0], word_third[15:6]};
      pos_u = {st1_in.turns[POS_W-SINGLE_W-1:0], st1_in.single};
      lin_t = (LIN_BASE - pos_u) * POS_W'(LIN_SCALE);
      st1_in.mode = cfg.mode;
      if (cfg.mode == BOARD_MODE_LINEAR) begin
         st1_in.neg = lin_t[POS_W-1];
         st1_in.mag = lin_t[POS_W-1] ? (POS_W'(0) - lin_t) : lin_t;
      end else begin
         st1_in.neg = pos_u[POS_W-1];
         st1_in.mag = pos_u[POS_W-1] ? (POS_W'(0) - pos_u) : pos_u;
      end
   end

   // Stage 2: shared reciprocal multiplier for the divide by counts or by
   // the linear divisor.
   always_comb begin
      div_magic = (st1_ff.mode == BOARD_MODE_LINEAR) ? LIN_MAGIC : DIV_MAGIC;
      div_prod  = PROD_W'(st1_ff.mag) * PROD_W'(div_magic);
      st2_in.turns  = st1_ff.turns;
      st2_in.single = st1_ff.single;
      st2_in.mode   = st1_ff.mode;
      st2_in.neg    = st1_ff.neg;
      if (st1_ff.mode == BOARD_MODE_LINEAR) begin
         st2_in.quo = Q_W'(div_prod >> LIN_SH);
      end else begin
         st2_in.quo = Q_W'(div_prod >> DIV_SH);
      end
   end

   // Stage 3: restore the sign, apply the offset and fold into a turn.
   always_comb begin
      quo_s = st2_ff.neg ? (POS_W'(0) - POS_W'(st2_ff.quo)) : POS_W'(st2_ff.quo);
      mod_t = POS_W'(FULL_TURN) - (quo_s - POS_W'(cfg.offset));
      st3_in.turns   = st2_ff.turns;
      st3_in.single  = st2_ff.single;
      st3_in.mode    = st2_ff.mode;
      st3_in.lin_raw = RAW_W'(quo_s);
      st3_in.neg     = mod_t[POS_W-1];
      st3_in.mag     = mod_t[POS_W-1] ? (POS_W'(0) - mod_t) : mod_t;
   end

   // Stage 4: quotient of the full-turn remainder.
   always_comb begin
      mod_prod = PROD_W'(st3_ff.mag) * PROD_W'(MOD_MAGIC);
      st4_in.turns   = st3_ff.turns;
      st4_in.single  = st3_ff.single;
      st4_in.mode    = st3_ff.mode;
      st4_in.lin_raw = st3_ff.lin_raw;
      st4_in.neg     = st3_ff.neg;
      st4_in.mag     = st3_ff.mag;
      st4_in.quo     = MOD_Q_W'(mod_prod >> MOD_SH);
   end

   // Stage 5: remainder with the sign of the dividend, then mode select.
   always_comb begin
      rem = REM_W'(st4_ff.mag - POS_W'(st4_ff.quo) * POS_W'(FULL_TURN));
      mod_raw = st4_ff.neg ? (RAW_W'(0) - RAW_W'(rem)) : RAW_W'(rem);
      st5_in.turn_count  = st4_ff.turns;
      st5_in.single_turn = st4_ff.single;
      st5_in.angle = (st4_ff.mode == BOARD_MODE_LINEAR) ? st4_ff.lin_raw : mod_raw;
   end

   // Stage valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < CALC_STAGES; k++) begin
            if (stage_ready[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   // Stage payload registers.
   always_ff @(posedge clock) begin
      if (stage_ready[0]) st1_ff <= st1_in;
      if (stage_ready[1]) st2_ff <= st2_in;
      if (stage_ready[2]) st3_ff <= st3_in;
      if (stage_ready[3]) st4_ff <= st4_in;
      if (stage_ready[4]) st5_ff <= st5_in;
   end

endmodule : eaf_angle_calc
`default_nettype wire

// ===== hw/rtl/eaf_filter.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// eaf_filter: warm-up and outlier-rejecting moving average
// Keeps the sample window, its sum and the filtered angle, and holds the
// result register of the block.
// ---------------------------------------------------------------------------
module eaf_filter (
   input  logic                               clock,
   input  logic                               reset,
   input  eaf_pkg::cfg_type                   cfg,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  eaf_pkg::raw_item_type              in_item,
   output logic                               out_valid,
   input  logic                               out_ready,
   output logic signed [eaf_pkg::ANGLE_W-1:0] angle,
   output logic [eaf_pkg::TURN_W-1:0]         turn_count,
   output logic [eaf_pkg::SINGLE_W-1:0]       single_turn,
   output logic                               warmed_up,
   output logic                               sample_rejected
);
   import eaf_pkg::*;

   typedef struct packed {
      logic signed [ANGLE_W-1:0] angle;
      logic [TURN_W-1:0]         turn_count;
      logic [SINGLE_W-1:0]       single_turn;
      logic                      warmed_up;
      logic                      sample_rejected;
   } rsp_type;

   logic signed [RAW_W-1:0] window_ff [AVG_LEN];
   logic signed [RAW_W-1:0] window_in [AVG_LEN];
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    ready_flag_ff, ready_flag_in;
   logic signed [RAW_W-1:0] filtered_ff, filtered_in;
   rsp_type                 rsp_ff, rsp_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   logic                    take;
   logic signed [RAW_W:0]   diff;
   logic [RAW_W:0]          abs_diff;
   logic                    near;
   logic                    warm_push;
   logic                    push;
   logic signed [SUM_W-1:0] sum_push;
   logic [MEAN_N-1:0]       sum_mag;
   logic [MEAN_PROD_W-1:0]  mean_prod;
   logic [RAW_W-1:0]        mean_mag;
   logic signed [RAW_W-1:0] mean;

   // The result register frees up when its transfer completes.
   assign in_ready = !rsp_valid_ff || out_ready;
   assign take     = in_valid && in_ready;

   // Distance to the filtered angle and the accept decision.
   always_comb begin
      diff      = (RAW_W+1)'(in_item.angle) - (RAW_W+1)'(filtered_ff);
      abs_diff  = diff[RAW_W] ? ((RAW_W+1)'(0) - diff) : diff;
      near      = abs_diff < (RAW_W+1)'(cfg.threshold);
      warm_push = !ready_flag_ff && (count_ff < CNT_W'(AVG_LEN));
      push      = ready_flag_ff ? near : warm_push;
   end

   // Window sum after the push and its truncated mean.
   always_comb begin
      sum_push  = sum_ff - SUM_W'(window_ff[0]) + SUM_W'(in_item.angle);
      sum_mag   = MEAN_N'(sum_push[SUM_W-1] ? (SUM_W'(0) - sum_push) : sum_push);
      mean_prod = MEAN_PROD_W'(sum_mag) * MEAN_PROD_W'(MEAN_MAGIC);
      mean_mag  = RAW_W'(mean_prod >> MEAN_SH);
      mean      = sum_push[SUM_W-1] ? (RAW_W'(0) - mean_mag) : mean_mag;
   end

   // Filter state, updated on each input transfer.
   always_comb begin
      window_in     = window_ff;
      sum_in        = sum_ff;
      count_in      = count_ff;
      ready_flag_in = ready_flag_ff;
      filtered_in   = filtered_ff;
      if (take) begin
         ready_flag_in = ready_flag_ff || !warm_push;
         if (warm_push) begin
            count_in = count_ff + CNT_W'(1);
         end
         if (push) begin
            for (int i = 0; i < AVG_LEN - 1; i++) begin
               window_in[i] = window_ff[i+1];
            end
            window_in[AVG_LEN-1] = in_item.angle;
            sum_in      = sum_push;
            filtered_in = mean;
         end
      end
   end

   // Result register contents.
   always_comb begin
      rsp_in.turn_count      = in_item.turn_count;
      rsp_in.single_turn     = in_item.single_turn;
      rsp_in.warmed_up       = ready_flag_ff || !warm_push;
      rsp_in.sample_rejected = ready_flag_ff && !near;
      if (ready_flag_ff) begin
         rsp_in.angle = ANGLE_W'(push ? mean : filtered_ff);
      end else begin
         rsp_in.angle = ANGLE_W'(in_item.angle);
      end
      rsp_valid_in = take || (rsp_valid_ff && !out_ready);
   end

   // State and result valid registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < AVG_LEN; i++) begin
            window_ff[i] <= '0;
         end
         sum_ff        <= '0;
         count_ff      <= '0;
         ready_flag_ff <= 1'b0;
         filtered_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         window_ff     <= window_in;
         sum_ff        <= sum_in;
         count_ff      <= count_in;
         ready_flag_ff <= ready_flag_in;
         filtered_ff   <= filtered_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (take) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid       = rsp_valid_ff;
   assign angle           = rsp_ff.angle;
   assign turn_count      = rsp_ff.turn_count;
   assign single_turn     = rsp_ff.single_turn;
   assign warmed_up       = rsp_ff.warmed_up;
   assign sample_rejected = rsp_ff.sample_rejected;

endmodule : eaf_filter
`default_nettype wire

// ===== hw/rtl/encoder_angle_filter_unit.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// encoder_angle_filter_unit: encoder position to filtered joint angle
// Top level with the configuration registers, the raw angle pipeline and
// the moving-average filter.
// ---------------------------------------------------------------------------
// The block takes one set of three encoder words per transfer and returns
// one result per set, in order. A new set is accepted in every cycle while
// the result side is not stalled. Each set passes through the five stages
// of the angle pipeline, whose two reciprocal multipliers (divide by counts
// or linear divisor, then the full-turn remainder) each sit in a stage of
// their own, and then through the result register of the filter, which
// closes its window update and mean in that stage, so the threshold test
// of a sample always sees the mean left by the last sample that entered the
// window. The sample window is cleared by reset at once, so no clearing pass
// is needed. Configuration writes are meant for idle periods only.
module encoder_angle_filter_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [eaf_pkg::WORD_W-1:0]            req_word_first,
   input  logic [eaf_pkg::WORD_W-1:0]            req_word_second,
   input  logic [eaf_pkg::WORD_W-1:0]            req_word_third,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [eaf_pkg::ANGLE_W-1:0]    rsp_angle,
   output logic [eaf_pkg::TURN_W-1:0]            rsp_turn_count,
   output logic [eaf_pkg::SINGLE_W-1:0]          rsp_single_turn,
   output logic                                  rsp_warmed_up,
   output logic                                  rsp_sample_rejected,
   input  logic                                  csr_wr_en,
   input  logic [eaf_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [eaf_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import eaf_pkg::*;

   cfg_type      cfg_ff, cfg_in;
   logic         raw_valid;
   logic         raw_ready;
   raw_item_type raw_item;

   // Register write decode; unknown indexes are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ANGLE_OFFSET:     cfg_in.offset    = csr_wdata[POS_W-1:0];
            CSR_BOARD_MODE:       cfg_in.mode      = csr_wdata[0];
            CSR_REJECT_THRESHOLD: cfg_in.threshold = csr_wdata[THR_W-1:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.offset    <= '0;
         cfg_ff.mode      <= BOARD_MODE_DIVIDED;
         cfg_ff.threshold <= THRESHOLD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Raw angle pipeline.
   eaf_angle_calc u_calc (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .in_valid    (req_valid),
      .in_ready    (req_ready),
      .word_first  (req_word_first),
      .word_second (req_word_second),
      .word_third  (req_word_third),
      .out_valid   (raw_valid),
      .out_ready   (raw_ready),
      .out_item    (raw_item)
   );

   // Filter and result register.
   eaf_filter u_filter (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .in_valid        (raw_valid),
      .in_ready        (raw_ready),
      .in_item         (raw_item),
      .out_valid       (rsp_valid),
      .out_ready       (rsp_ready),
      .angle           (rsp_angle),
      .turn_count      (rsp_turn_count),
      .single_turn     (rsp_single_turn),
      .warmed_up       (rsp_warmed_up),
      .sample_rejected (rsp_sample_rejected)
   );

endmodule : encoder_angle_filter_unit
`default_nettype wire
